FILE: hw/rtl/smp_pkg.sv
// Shared types and constants for the SHA message padder.
// Used by smp_ctrl, smp_datapath and sha_message_padder; no dependencies.
package smp_pkg;

    localparam int COUNT_W = 61;
    localparam int POS_W   = 6;

    localparam logic [7:0]       PAD_MARK = 8'h80;
    localparam logic [POS_W-1:0] LEN_POS  = 6'd56;
    localparam logic [POS_W-1:0] LAST_POS = 6'd63;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MARK,
        ST_ZERO,
        ST_LEN
    } state_t;

    typedef enum logic [1:0] {
        SRC_DATA,
        SRC_MARK,
        SRC_ZERO,
        SRC_LEN
    } src_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic push;
        src_t src;
        logic count_inc;
        logic load_pos;
        logic step_pos;
        logic last;
        logic clear_count;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic can_push;
        logic word_full;
        logic mark_to_len;
        logic zero_to_len;
        logic len_last;
    } status_t;

endpackage

FILE: hw/rtl/smp_datapath.sv
// Datapath of the SHA message padder: byte packer, byte counter, pad position
// and output word register. Depends on smp_pkg.
module smp_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       data_byte,
    input  smp_pkg::cmd_t    cmd,
    output smp_pkg::status_t sts,
    output logic [31:0]      word_out,
    output logic             final_word,
    output logic             out_valid,
    input  logic             out_ready
);
    import smp_pkg::*;

    logic [COUNT_W-1:0] count_reg, count_next;
    logic [23:0]        part_reg, part_next;
    logic [1:0]         fill_reg, fill_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [31:0]        word_reg, word_next;
    logic               final_reg, final_next;
    logic               valid_reg, valid_next;

    logic [63:0]        len_bits;
    logic [2:0]         len_idx;
    logic [7:0]         push_byte;
    logic [POS_W-1:0]   mark_pos;
    logic [POS_W-1:0]   pos_inc;
    logic               load_word;

    assign len_bits = {count_reg, 3'b000};
    assign len_idx  = ~pos_reg[2:0];
    assign mark_pos = count_reg[POS_W-1:0] + POS_W'(1);
    assign pos_inc  = pos_reg + POS_W'(1);

    // Pick the byte to pack
    always_comb
    begin
        case (cmd.src)
            SRC_DATA: push_byte = data_byte;
            SRC_MARK: push_byte = PAD_MARK;
            SRC_ZERO: push_byte = 8'h00;
            SRC_LEN:  push_byte = len_bits[{len_idx, 3'b000} +: 8];
            default:  push_byte = 8'h00;
        endcase
    end

    assign load_word = cmd.push && (fill_reg == 2'd3);

    // Report status
    always_comb
    begin
        sts.word_full   = (fill_reg == 2'd3);
        sts.can_push    = !(sts.word_full && valid_reg && !out_ready);
        sts.mark_to_len = (mark_pos == LEN_POS);
        sts.zero_to_len = (pos_inc == LEN_POS);
        sts.len_last    = (pos_reg == LAST_POS);
    end

    // Pack bytes, count, and load the output word
    always_comb
    begin
        count_next = count_reg;
        part_next  = part_reg;
        fill_next  = fill_reg;
        pos_next   = pos_reg;
        word_next  = word_reg;
        final_next = final_reg;
        valid_next = valid_reg && !out_ready;

        if (cmd.push)
        begin
            if (load_word)
            begin
                word_next  = {part_reg, push_byte};
                final_next = cmd.last;
                valid_next = 1'b1;
                part_next  = '0;
                fill_next  = '0;
            end
            else
            begin
                part_next = {part_reg[15:0], push_byte};
                fill_next = fill_reg + 2'd1;
            end
        end

        if (cmd.count_inc)
            count_next = count_reg + COUNT_W'(1);
        if (cmd.clear_count)
            count_next = '0;

        if (cmd.load_pos)
            pos_next = mark_pos;
        else if (cmd.step_pos)
            pos_next = pos_inc;
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            part_reg  <= '0;
            fill_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            part_reg  <= part_next;
            fill_reg  <= fill_next;
            valid_reg <= valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        word_reg  <= word_next;
        final_reg <= final_next;
    end

    assign word_out   = word_reg;
    assign final_word = final_reg;
    assign out_valid  = valid_reg;

endmodule

FILE: hw/rtl/smp_ctrl.sv
// Controller of the SHA message padder: takes requests and sequences the
// padding and length bytes. Depends on smp_pkg.
module smp_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             has_byte,
    input  logic             end_of_message,
    input  smp_pkg::status_t sts,
    output smp_pkg::cmd_t    cmd,
    output smp_pkg::state_t  state
);
    import smp_pkg::*;

    state_t state_reg, state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Decide next state and commands
    always_comb
    begin
        state_next      = state_reg;
        in_ready        = 1'b0;
        cmd.push        = 1'b0;
        cmd.src         = SRC_DATA;
        cmd.count_inc   = 1'b0;
        cmd.load_pos    = 1'b0;
        cmd.step_pos    = 1'b0;
        cmd.last        = 1'b0;
        cmd.clear_count = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = sts.can_push;
                if (in_valid && sts.can_push)
                begin
                    cmd.push      = has_byte;
                    cmd.count_inc = has_byte;
                    if (end_of_message)
                        state_next = ST_MARK;
                end
            end
            ST_MARK:
            begin
                if (sts.can_push)
                begin
                    cmd.push     = 1'b1;
                    cmd.src      = SRC_MARK;
                    cmd.load_pos = 1'b1;
                    state_next   = sts.mark_to_len ? ST_LEN : ST_ZERO;
                end
            end
            ST_ZERO:
            begin
                if (sts.can_push)
                begin
                    cmd.push     = 1'b1;
                    cmd.src      = SRC_ZERO;
                    cmd.step_pos = 1'b1;
                    if (sts.zero_to_len)
                        state_next = ST_LEN;
                end
            end
            ST_LEN:
            begin
                if (sts.can_push)
                begin
                    cmd.push     = 1'b1;
                    cmd.src      = SRC_LEN;
                    cmd.step_pos = 1'b1;
                    if (sts.len_last)
                    begin
                        cmd.last        = 1'b1;
                        cmd.clear_count = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign state = state_reg;

endmodule

FILE: hw/rtl/sha_message_padder.sv
// Top level of the SHA-1/SHA-256 message padder: controller plus datapath.
// Depends on smp_pkg, smp_ctrl and smp_datapath.
//
// Message bytes are taken one per cycle while in_ready is high and packed
// big-endian into 32-bit words, first byte in bits 31..24. A request with
// end_of_message set ends the message (a byte it carries is packed first);
// the block then appends 0x80, zero bytes up to 56 mod 64 and the 64-bit
// bit length, and flags the last word with final_word. The byte-wide packer
// places one padding or length byte per cycle unless stalled, so after an
// end marker the block is busy appending the 0x80 byte, 0 to 63 zero bytes
// and 8 length bytes, and while a finished word sits in the output register.
// While a word waits, a new request is still taken unless the packer already
// holds three bytes; then every request waits until the word leaves.
module sha_message_padder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] word_out,
    output logic        final_word
);
    import smp_pkg::*;

    cmd_t    cmd;
    status_t sts;
    state_t  state;

    smp_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .has_byte       (has_byte),
        .end_of_message (end_of_message),
        .sts            (sts),
        .cmd            (cmd),
        .state          (state)
    );

    smp_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_byte  (data_byte),
        .cmd        (cmd),
        .sts        (sts),
        .word_out   (word_out),
        .final_word (final_word),
        .out_valid  (out_valid),
        .out_ready  (out_ready)
    );

    // Never push a byte when a completed word has nowhere to go
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.push && !sts.can_push))
        else $error("byte pushed while output word is blocked");

    // The last length byte always completes a word
    a_last_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.last |-> (cmd.push && sts.word_full))
        else $error("final push does not complete a word");

    // The final word shows up at the output next cycle
    a_last_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.last |=> (out_valid && final_word && (state == ST_IDLE)))
        else $error("final word not presented after last push");

endmodule
